// ===== hw/rtl/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants of the LRU replacement cache: field widths,
// controller states and the control word that walks down the cell row.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int unsigned KEY_W       = 16;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned HIT_TOTAL_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } ctrl_state_e;

  // Control part of the lookup wave that moves one cell per cycle.
  typedef struct packed {
    logic live;
    logic done;
    logic hit;
  } wave_ctl_t;

endpackage

// ===== hw/rtl/lrc_req_if.sv =====
// ----------------------------------------------------------------------------
// lrc_req_if
// Request channel of the LRU replacement cache: one key per request.
// ----------------------------------------------------------------------------
interface lrc_req_if import lrc_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);

endinterface

// ===== hw/rtl/lrc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lrc_rsp_if
// Result channel of the LRU replacement cache: hit, slot, eviction and the
// running hit count.
// ----------------------------------------------------------------------------
interface lrc_rsp_if import lrc_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [SLOT_W-1:0]      slot;
  logic                   evicted;
  logic [HIT_TOTAL_W-1:0] hit_total;

  modport source (output valid, output hit, output slot, output evicted,
                  output hit_total, input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input hit_total, output ready);

endinterface

// ===== hw/rtl/lrc_cell.sv =====
// ----------------------------------------------------------------------------
// lrc_cell
// One position of the recency stack. The cell holds one entry (key and the
// physical slot it lives in). When the lookup wave passes, the cell takes the
// entry carried from its upper neighbor and hands its own entry further down,
// until the key is found or an empty cell is reached.
// ----------------------------------------------------------------------------
module lrc_cell import lrc_pkg::*; #(
  parameter int unsigned KW = 16,
  parameter int unsigned IW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] idx_i,
  input  wave_ctl_t     wave_i,
  input  logic [KW-1:0] key_i,
  input  logic [KW-1:0] ent_key_i,
  input  logic [IW-1:0] ent_slot_i,
  input  logic [IW-1:0] res_slot_i,
  input  logic          fix_en_i,
  input  logic [IW-1:0] fix_slot_i,
  output wave_ctl_t     wave_o,
  output logic [KW-1:0] key_o,
  output logic [KW-1:0] ent_key_o,
  output logic [IW-1:0] ent_slot_o,
  output logic [IW-1:0] res_slot_o
);

  logic          valid_q, valid_d;
  logic [KW-1:0] key_q, key_d;
  logic [IW-1:0] slot_q, slot_d;
  wave_ctl_t     wave_q, wave_d;
  logic [KW-1:0] req_key_q, ent_key_q, ent_key_d;
  logic [IW-1:0] ent_slot_q, ent_slot_d, res_slot_q, res_slot_d;

  always_comb begin
    valid_d    = valid_q;
    key_d      = key_q;
    slot_d     = slot_q;
    wave_d     = wave_i;
    ent_key_d  = ent_key_i;
    ent_slot_d = ent_slot_i;
    res_slot_d = res_slot_i;
    if (wave_i.live && !wave_i.done) begin
      // The carried entry always lands here; what happens to ours depends on
      // whether it is empty, the match, or just another older entry.
      valid_d = 1'b1;
      key_d   = ent_key_i;
      slot_d  = ent_slot_i;
      if (!valid_q) begin
        wave_d.done = 1'b1;
        res_slot_d  = idx_i;
      end else if (key_q == key_i) begin
        wave_d.done = 1'b1;
        wave_d.hit  = 1'b1;
        res_slot_d  = slot_q;
      end else begin
        ent_key_d  = key_q;
        ent_slot_d = slot_q;
      end
    end
    if (fix_en_i) begin
      slot_d = fix_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wave_q  <= wave_ctl_t'(0);
    end else begin
      valid_q <= valid_d;
      wave_q  <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    slot_q     <= slot_d;
    req_key_q  <= key_i;
    ent_key_q  <= ent_key_d;
    ent_slot_q <= ent_slot_d;
    res_slot_q <= res_slot_d;
  end

  assign wave_o     = wave_q;
  assign key_o      = req_key_q;
  assign ent_key_o  = ent_key_q;
  assign ent_slot_o = ent_slot_q;
  assign res_slot_o = res_slot_q;

endmodule

// ===== hw/rtl/lru_replacement_cache.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_cache
// Fully associative key cache with true LRU replacement, built as a row of
// recency-stack cells.
// ----------------------------------------------------------------------------
// The cache holds ENTRIES keys ordered from most to least recently used in a
// row of cells; a request with a nonzero key walks the whole row, one cell per
// clock, and the next request is accepted only after the walk has ended; a
// request with key zero skips the walk and goes straight to the result. The
// result sits in an output register, so a new request is accepted while the
// previous result still waits to be taken. Slots fill in order from 0; once
// the cache is full, the least recently used entry is replaced. hit_total
// saturates at its maximum.
module lru_replacement_cache import lrc_pkg::*; #(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lrc_req_if.sink   req_i,
  lrc_rsp_if.source rsp_o
);

  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned SW = (IW > SLOT_W) ? IW : SLOT_W;

  ctrl_state_e state_q, state_d;

  logic          req_ready;
  logic          accept;
  logic [KW-1:0] req_key;
  logic          key_zero;
  logic          load_res, zero_res, load_out;
  logic          walk_end;
  logic          tail_hit, tail_evict;
  logic [IW-1:0] tail_slot;
  logic [SW-1:0] slot_ext;

  logic                   res_hit_q, res_evict_q;
  logic [IW-1:0]          res_slot_q;
  logic [HIT_TOTAL_W-1:0] hits_q;
  logic                   out_valid_q, out_hit_q, out_evict_q;
  logic [SLOT_W-1:0]      out_slot_q;
  logic [HIT_TOTAL_W-1:0] out_total_q;

  wave_ctl_t     wave_c     [ENTRIES+1];
  logic [KW-1:0] key_c      [ENTRIES+1];
  logic [KW-1:0] ent_key_c  [ENTRIES+1];
  logic [IW-1:0] ent_slot_c [ENTRIES+1];
  logic [IW-1:0] res_slot_c [ENTRIES+1];

  assign req_key   = req_i.key[KW-1:0];
  assign key_zero  = (req_key == '0);
  assign req_ready = (state_q == ST_IDLE);
  assign req_i.ready = req_ready;
  assign accept    = req_i.valid && req_ready;

  // The new key enters the top cell as the carried entry; its slot is not
  // known yet and is written into the top cell when the walk ends.
  assign wave_c[0]     = '{live: accept && !key_zero, done: 1'b0, hit: 1'b0};
  assign key_c[0]      = req_key;
  assign ent_key_c[0]  = req_key;
  assign ent_slot_c[0] = '0;
  assign res_slot_c[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrc_cell #(
      .KW (KW),
      .IW (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IW'(i)),
      .wave_i     (wave_c[i]),
      .key_i      (key_c[i]),
      .ent_key_i  (ent_key_c[i]),
      .ent_slot_i (ent_slot_c[i]),
      .res_slot_i (res_slot_c[i]),
      .fix_en_i   ((i == 0) ? walk_end : 1'b0),
      .fix_slot_i (tail_slot),
      .wave_o     (wave_c[i+1]),
      .key_o      (key_c[i+1]),
      .ent_key_o  (ent_key_c[i+1]),
      .ent_slot_o (ent_slot_c[i+1]),
      .res_slot_o (res_slot_c[i+1])
    );
  end

  // A wave that leaves the row unfinished carries the least recently used
  // entry, whose slot is reused for the new key.
  assign tail_hit   = wave_c[ENTRIES].hit;
  assign tail_evict = !wave_c[ENTRIES].done;
  assign tail_slot  = wave_c[ENTRIES].done ? res_slot_c[ENTRIES] : ent_slot_c[ENTRIES];
  assign walk_end   = (state_q == ST_WALK) && wave_c[ENTRIES].live;

  always_comb begin
    state_d  = state_q;
    load_res = 1'b0;
    zero_res = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (key_zero) begin
            zero_res = 1'b1;
            state_d  = ST_RESULT;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          load_res = 1'b1;
          state_d  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_res && tail_hit && (hits_q != '1)) begin
        hits_q <= hits_q + HIT_TOTAL_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign slot_ext = SW'(res_slot_q);

  always_ff @(posedge clk_i) begin
    if (zero_res) begin
      res_hit_q   <= 1'b0;
      res_evict_q <= 1'b0;
      res_slot_q  <= '0;
    end else if (load_res) begin
      res_hit_q   <= tail_hit;
      res_evict_q <= tail_evict;
      res_slot_q  <= tail_slot;
    end
    if (load_out) begin
      out_hit_q   <= res_hit_q;
      out_evict_q <= res_evict_q;
      out_slot_q  <= slot_ext[SLOT_W-1:0];
      out_total_q <= hits_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.slot      = out_slot_q;
  assign rsp_o.evicted   = out_evict_q;
  assign rsp_o.hit_total = out_total_q;

  // The wave may only leave the row while the controller waits for it.
  a_tail_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_c[ENTRIES].live |-> (state_q == ST_WALK))
    else $error("lookup wave left the cell row outside a walk");

  // A request cannot both hit and evict.
  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.evicted))
    else $error("result reports both hit and eviction");

  // The hit counter never goes backward.
  a_hits_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hits_q >= $past(hits_q)))
    else $error("hit counter decreased");

  // A launched walk always puts the controller into the walk state.
  a_launch_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_c[0].live |=> (state_q == ST_WALK))
    else $error("walk launched without entering the walk state");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU replacement cache. Keys are sent through the
// request channel, a behavioral copy of the cache predicts each result, and
// every result is compared field by field in order of acceptance.
// ----------------------------------------------------------------------------
module testbench import lrc_pkg::*; ();

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned KEY_BITS    = 16;
  localparam int unsigned AGE_W       = 7;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic                   evicted;
    logic [HIT_TOTAL_W-1:0] hit_total;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni;

  lrc_req_if req_if ();
  lrc_rsp_if rsp_if ();

  lru_replacement_cache #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Behavioral copy of the cache contents.
  logic [KEY_W-1:0]       cache_keys [ENTRIES];
  logic [AGE_W-1:0]       cache_ages [ENTRIES];
  int unsigned            fill_count;
  logic [HIT_TOTAL_W-1:0] hit_count;

  logic [KEY_W-1:0] pending_keys [$];
  lookup_result_t   predicted_lookups [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned keys_queued;
  int unsigned keys_accepted;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned hits_checked;
  int unsigned misses_checked;
  int unsigned evictions_checked;
  lookup_result_t want;

  function automatic lookup_result_t cache_lookup(input logic [KEY_W-1:0] key);
    lookup_result_t   r;
    logic             found;
    int unsigned      j;
    int unsigned      target;
    logic [AGE_W-1:0] hit_age;
    r      = '0;
    found  = 1'b0;
    target = 0;
    if (key != '0) begin
      for (j = 0; j < fill_count; j++) begin
        if (!found && cache_keys[j] == key) begin
          found  = 1'b1;
          target = j;
        end
      end
      if (found) begin
        // Only entries more recent than the hit one move back by one.
        hit_age = cache_ages[target];
        for (j = 0; j < fill_count; j++) begin
          if (cache_ages[j] < hit_age) cache_ages[j]++;
        end
        cache_ages[target] = '0;
        if (hit_count != '1) hit_count++;
        r.hit = 1'b1;
      end else if (fill_count < ENTRIES) begin
        target             = fill_count;
        cache_keys[target] = key;
        fill_count++;
        for (j = 0; j < fill_count; j++) cache_ages[j]++;
        cache_ages[target] = '0;
      end else begin
        // Oldest entry; a tie would go to the highest index.
        target = 0;
        for (j = 1; j < ENTRIES; j++) begin
          if (cache_ages[j] >= cache_ages[target]) target = j;
        end
        for (j = 0; j < fill_count; j++) cache_ages[j]++;
        cache_ages[target] = '0;
        cache_keys[target] = key;
        r.evicted          = 1'b1;
      end
      r.slot = target[SLOT_W-1:0];
    end
    r.hit_total = hit_count;
    return r;
  endfunction

  task automatic queue_key(input logic [KEY_W-1:0] key);
    pending_keys.push_back(key);
    keys_queued++;
  endtask

  // A burst of requests drawn from one working set, so that the cache sees
  // repeated keys (hits), sets larger than the cache (evictions) and noise.
  task automatic queue_burst();
    int unsigned      style;
    int unsigned      set_size;
    int unsigned      burst_len;
    int unsigned      i;
    logic             cyclic;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    style     = $urandom_range(99);
    burst_len = $urandom_range(16, 64);
    base      = KEY_W'($urandom_range(65535));
    cyclic    = 1'($urandom_range(1));
    if (style < 25) set_size = $urandom_range(1, 8);
    else if (style < 55) set_size = $urandom_range(40, ENTRIES);
    else if (style < 80) set_size = $urandom_range(ENTRIES + 1, ENTRIES + 32);
    else set_size = 0;
    for (i = 0; i < burst_len; i++) begin
      if ($urandom_range(99) < 3) begin
        key = '0;
      end else if (set_size == 0) begin
        key = KEY_W'($urandom_range(1, 65535));
      end else begin
        key = KEY_W'(base + (cyclic ? (i % set_size) : $urandom_range(set_size - 1)));
        if (key == '0) key = 16'd1;
      end
      queue_key(key);
    end
  endtask

  // Holds off further requests until every queued request is accepted and
  // every predicted result has been taken.
  task automatic wait_for_drain();
    while (keys_accepted != keys_queued || predicted_lookups.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned n_keys);
    int unsigned target_count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target_count  = keys_queued + n_keys;
    while (keys_queued < target_count) queue_burst();
    wait_for_drain();
  endtask

  always #10 clk_i = ~clk_i;

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.key   <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predicted_lookups.push_back(cache_lookup(req_if.key));
        keys_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.key   <= pending_keys.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_lookups.size() == 0) begin
          $display("%0t: result with nothing expected: hit=%0b slot=%0d evicted=%0b total=%0d",
                   $time, rsp_if.hit, rsp_if.slot, rsp_if.evicted, rsp_if.hit_total);
          error_count++;
        end else begin
          want = predicted_lookups.pop_front();
          if (rsp_if.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_if.hit);
            error_count++;
          end
          if (rsp_if.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_if.slot);
            error_count++;
          end
          if (rsp_if.evicted !== want.evicted) begin
            $display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
                     rsp_if.evicted);
            error_count++;
          end
          if (rsp_if.hit_total !== want.hit_total) begin
            $display("%0t: hit_total expected %0d actual %0d", $time, want.hit_total,
                     rsp_if.hit_total);
            error_count++;
          end
          if (want.hit) hits_checked++;
          else misses_checked++;
          if (want.evicted) evictions_checked++;
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 63;
    fill_count    = 0;
    hit_count     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_keys[i] = '0;
      cache_ages[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: key zero on an empty cache, the extremes of the key, single
    // bits and alternating patterns, repeats for hits, key zero after hits.
    queue_key(16'h0000);
    queue_key(16'h0001);
    queue_key(16'h0001);
    queue_key(16'hFFFF);
    queue_key(16'h8000);
    queue_key(16'h7FFF);
    queue_key(16'hAAAA);
    queue_key(16'h5555);
    queue_key(16'hFFFF);
    queue_key(16'h0001);
    queue_key(16'h0000);
    queue_key(16'h8000);
    wait_for_drain();

    run_random_phase(37, 63, 560);
    run_random_phase(63, 37, 560);
    run_random_phase(0, 0, 570);

    repeat (ENTRIES + 4) @(negedge clk_i);
    if (predicted_lookups.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_lookups.size());
      error_count++;
    end

    $display("Checked %0d lookups: %0d hits, %0d misses of which %0d evicted an entry.",
             hits_checked + misses_checked, hits_checked, misses_checked, evictions_checked);
    $display("Keys spanned small and over-full working sets, random tags and key zero,");
    $display("under sender/receiver idling of 37/63, 63/37 and none, with full drains.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_req_if.sv
hw/rtl/lrc_rsp_if.sv
hw/rtl/lrc_cell.sv
hw/rtl/lru_replacement_cache.sv
tb/sv/testbench.sv
